@@ hdl/scv_pkg.sv @@
// Package for the sparse constraint violation block.
// Holds field widths, action codes, saturation helpers and the row hand-off struct.
// No dependencies.
package scv_pkg;

    localparam int DATA_W = 32;   // Q16.16 inputs
    localparam int COL_W  = 10;   // column field width
    localparam int PROD_W = 64;   // exact Q32.32 product
    localparam int FRAC_W = 16;   // fraction bits dropped after the multiply
    localparam int ACC_W  = 48;   // signed Q32.16 accumulator and residual
    localparam int VIOL_W = 47;   // unsigned Q31.16 violation, sum and max
    localparam int CNT_W  = 16;   // row counter and equality count

    // Action codes
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TERM = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [VIOL_W-1:0]       VIOL_MAX = {VIOL_W{1'b1}};
    localparam logic [CNT_W-1:0]        CNT_MAX  = {CNT_W{1'b1}};

    // Row markers and bound that travel with a term
    typedef struct packed {
        logic                     row_end;
        logic                     last_row;
        logic signed [DATA_W-1:0] bound;
    } t_term_ctl;

    // A finished row, handed from the accumulator to the metrics stages
    typedef struct packed {
        logic                     valid;
        logic                     is_eq;
        logic                     last_row;
        logic signed [DATA_W-1:0] bound;
        logic signed [ACC_W-1:0]  row_value;
    } t_row_done;

    // Clamp a one-bit-grown signed sum to the 48-bit signed range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1]) begin
            r = v[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/scv_store.sv @@
// Vector element store for the sparse constraint violation block.
// One write or one registered read per transaction; depends on scv_pkg.
module scv_store #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic                              i_req,
    input  logic                              i_action,
    input  logic [scv_pkg::COL_W-1:0]         i_column,
    input  logic signed [scv_pkg::DATA_W-1:0] i_x_value,
    output logic signed [scv_pkg::DATA_W-1:0] o_rd_data,
    output logic                              o_hit
);

    localparam int AW    = $clog2(MAX_COLUMNS);
    localparam int EXT_W = ((AW > scv_pkg::COL_W) ? AW : scv_pkg::COL_W) + 1;

    logic signed [scv_pkg::DATA_W-1:0] r_mem [MAX_COLUMNS];
    logic signed [scv_pkg::DATA_W-1:0] r_rd_data;
    logic                              r_hit;
    logic [EXT_W-1:0]                  col_ext;
    logic                              in_range;
    logic [AW-1:0]                     idx;

    // Columns past the store are dropped on load and read as zero
    assign col_ext  = EXT_W'(i_column);
    assign in_range = col_ext < EXT_W'(MAX_COLUMNS);
    assign idx      = col_ext[AW-1:0];

    // Memory write on a load transaction
    always_ff @(posedge i_clk) begin
        if (i_req && (i_action == scv_pkg::ACTION_LOAD) && in_range) begin
            r_mem[idx] <= i_x_value;
        end
    end

    // Registered read on a term transaction; held while the pipe stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= in_range;
            if (i_req && (i_action == scv_pkg::ACTION_TERM) && in_range) begin
                r_rd_data <= r_mem[idx];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_hit     = r_hit;

endmodule

@@ hdl/scv_mac.sv @@
// Multiply-accumulate and row bookkeeping for the sparse constraint violation block.
// Product register, saturating row accumulator and row counter; depends on scv_pkg.
module scv_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_term_valid,
    input  logic signed [scv_pkg::DATA_W-1:0] i_coefficient,
    input  logic signed [scv_pkg::DATA_W-1:0] i_x_elem,
    input  logic                              i_hit,
    input  scv_pkg::t_term_ctl                i_ctl,
    input  logic [scv_pkg::CNT_W-1:0]         i_num_equalities,
    output scv_pkg::t_row_done                o_done
);

    logic signed [scv_pkg::PROD_W-1:0] r_prod;
    logic                              r_p_valid;
    scv_pkg::t_term_ctl                r_p_ctl;
    logic signed [scv_pkg::ACC_W-1:0]  r_acc;
    logic                              r_clear;
    logic [scv_pkg::CNT_W-1:0]         r_row_cnt;
    scv_pkg::t_row_done                r_done;

    logic signed [scv_pkg::DATA_W-1:0] x_sel;
    logic signed [scv_pkg::ACC_W-1:0]  addend;
    logic signed [scv_pkg::ACC_W-1:0]  base;
    logic signed [scv_pkg::ACC_W:0]    acc_sum;
    logic signed [scv_pkg::ACC_W-1:0]  n_acc;
    logic [scv_pkg::CNT_W-1:0]         n_row_cnt;

    // Out-of-range column contributes nothing
    assign x_sel = i_hit ? i_x_elem : '0;

    // Product stage: exact Q32.32
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= scv_pkg::PROD_W'(i_coefficient) * scv_pkg::PROD_W'(x_sel);
            r_p_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_term_valid;
        end
    end

    // Drop 16 fraction bits (floor), add to the row, saturate
    assign addend  = $signed(r_prod[scv_pkg::FRAC_W +: scv_pkg::ACC_W]);
    assign base    = r_clear ? '0 : r_acc;
    assign acc_sum = (scv_pkg::ACC_W+1)'(base) + (scv_pkg::ACC_W+1)'(addend);
    assign n_acc   = scv_pkg::sat_acc(acc_sum);

    // Row counter: clears after the last row, sticks at its top
    always_comb begin
        n_row_cnt = r_row_cnt;
        if (r_p_ctl.last_row) begin
            n_row_cnt = '0;
        end else if (r_row_cnt != scv_pkg::CNT_MAX) begin
            n_row_cnt = r_row_cnt + 1'b1;
        end
    end

    // Accumulator and row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_clear   <= 1'b0;
            r_row_cnt <= '0;
        end else if (i_en && r_p_valid) begin
            r_acc   <= n_acc;
            r_clear <= r_p_ctl.row_end;
            if (r_p_ctl.row_end) begin
                r_row_cnt <= n_row_cnt;
            end
        end
    end

    // Row hand-off register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done.valid <= 1'b0;
        end else if (i_en) begin
            r_done.valid <= r_p_valid && r_p_ctl.row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_done.is_eq     <= r_row_cnt < i_num_equalities;
            r_done.last_row  <= r_p_ctl.last_row;
            r_done.bound     <= r_p_ctl.bound;
            r_done.row_value <= n_acc;
        end
    end

    assign o_done = r_done;

endmodule

@@ hdl/scv_metrics.sv @@
// Residual, violation and running sum/max stages with the result register.
// Consumes finished rows from scv_mac; depends on scv_pkg.
module scv_metrics (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  scv_pkg::t_row_done                i_done,
    input  logic                              i_out_ready,
    output logic                              o_stall,
    output logic                              o_out_valid,
    output logic signed [scv_pkg::ACC_W-1:0]  o_residual,
    output logic [scv_pkg::VIOL_W-1:0]        o_violation_sum,
    output logic [scv_pkg::VIOL_W-1:0]        o_violation_max,
    output logic                              o_final_res
);

    // Residual stage
    logic                              r_r_valid;
    logic                              r_r_eq;
    logic                              r_r_last;
    logic signed [scv_pkg::ACC_W-1:0]  r_r_res;
    // Violation stage
    logic                              r_v_valid;
    logic                              r_v_last;
    logic signed [scv_pkg::ACC_W-1:0]  r_v_res;
    logic [scv_pkg::VIOL_W-1:0]        r_v_viol;
    // Running metrics and result register
    logic [scv_pkg::VIOL_W-1:0]        r_sum;
    logic [scv_pkg::VIOL_W-1:0]        r_max;
    logic                              r_out_valid;
    logic signed [scv_pkg::ACC_W-1:0]  r_out_res;
    logic [scv_pkg::VIOL_W-1:0]        r_out_sum;
    logic [scv_pkg::VIOL_W-1:0]        r_out_max;
    logic                              r_out_last;

    logic signed [scv_pkg::ACC_W:0]    diff;
    logic [scv_pkg::ACC_W-1:0]         mag;
    logic [scv_pkg::VIOL_W-1:0]        n_viol;
    logic [scv_pkg::VIOL_W:0]          sum_wide;
    logic [scv_pkg::VIOL_W-1:0]        n_sum;
    logic [scv_pkg::VIOL_W-1:0]        n_max;

    // Hold the pipe only when a result is ready and the result register is blocked
    assign o_stall = r_out_valid && !i_out_ready && r_v_valid;

    // Residual: row value minus bound, saturated
    assign diff = (scv_pkg::ACC_W+1)'(i_done.row_value) - (scv_pkg::ACC_W+1)'(i_done.bound);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (i_en) begin
            r_r_valid <= i_done.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r_eq   <= i_done.is_eq;
            r_r_last <= i_done.last_row;
            r_r_res  <= scv_pkg::sat_acc(diff);
        end
    end

    // Violation: absolute value on equalities, positive part on inequalities
    assign mag = r_r_res[scv_pkg::ACC_W-1] ? scv_pkg::ACC_W'(-r_r_res)
                                           : scv_pkg::ACC_W'(r_r_res);

    always_comb begin
        if (r_r_eq) begin
            n_viol = mag[scv_pkg::ACC_W-1] ? scv_pkg::VIOL_MAX : mag[scv_pkg::VIOL_W-1:0];
        end else if (r_r_res[scv_pkg::ACC_W-1]) begin
            n_viol = '0;
        end else begin
            n_viol = r_r_res[scv_pkg::VIOL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_valid <= 1'b0;
        end else if (i_en) begin
            r_v_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v_last <= r_r_last;
            r_v_res  <= r_r_res;
            r_v_viol <= n_viol;
        end
    end

    // Saturating sum and running max
    assign sum_wide = {1'b0, r_sum} + {1'b0, r_v_viol};
    assign n_sum    = sum_wide[scv_pkg::VIOL_W] ? scv_pkg::VIOL_MAX
                                                : sum_wide[scv_pkg::VIOL_W-1:0];
    assign n_max    = (r_v_viol > r_max) ? r_v_viol : r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_max <= '0;
        end else if (i_en && r_v_valid) begin
            r_sum <= r_v_last ? '0 : n_sum;
            r_max <= r_v_last ? '0 : n_max;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            if (r_v_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_v_valid) begin
            r_out_res  <= r_v_res;
            r_out_sum  <= n_sum;
            r_out_max  <= n_max;
            r_out_last <= r_v_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_residual      = r_out_res;
    assign o_violation_sum = r_out_sum;
    assign o_violation_max = r_out_max;
    assign o_final_res     = r_out_last;

endmodule

@@ hdl/sparse_constraint_violation.sv @@
// Top level of the sparse constraint violation block.
// Instantiates scv_store, scv_mac and scv_metrics; depends on scv_pkg.

// Takes one transaction per clock while o_in_ready is high: a vector load
// (action 0) or one nonzero constraint term (action 1), with rows sent in
// order and the last term of a row marked by row_end. Each row end yields one
// result; after the edge that accepts the term (that edge also registers the
// store read) it passes through multiply, accumulate, residual, violation and
// sum/max into the result register. The pipeline moves as a whole and halts
// only when a row result reaches the last stage while the result register is
// still held by the consumer; loads and mid-row terms keep flowing otherwise.
// Accumulate and running sum each feed back on their own register, setting
// the one item per clock rate while not halted. The vector store has
// MAX_COLUMNS entries and is not cleared: every column a term references must
// be loaded first. Write num_equalities only while the block is idle.
module sparse_constraint_violation #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scv_pkg::CNT_W-1:0]         i_cfg_data,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic [scv_pkg::COL_W-1:0]         i_column,
    input  logic signed [scv_pkg::DATA_W-1:0] i_x_value,
    input  logic signed [scv_pkg::DATA_W-1:0] i_coefficient,
    input  logic signed [scv_pkg::DATA_W-1:0] i_bound,
    input  logic                              i_row_end,
    input  logic                              i_last_row,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [scv_pkg::ACC_W-1:0]  o_residual,
    output logic [scv_pkg::VIOL_W-1:0]        o_violation_sum,
    output logic [scv_pkg::VIOL_W-1:0]        o_violation_max,
    output logic                              o_final_res
);

    logic [scv_pkg::CNT_W-1:0]         r_num_eq;
    logic                              r_t_valid;
    logic signed [scv_pkg::DATA_W-1:0] r_t_coef;
    scv_pkg::t_term_ctl                r_t_ctl;

    logic                              stall;
    logic                              en;
    logic                              accept;
    logic signed [scv_pkg::DATA_W-1:0] x_elem;
    logic                              hit;
    scv_pkg::t_row_done                row_done;

    assign en         = !stall;
    assign o_in_ready = en;
    assign accept     = i_in_valid && en;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_eq <= '0;
        end else if (i_cfg_valid) begin
            r_num_eq <= i_cfg_data;
        end
    end

    // Term register alongside the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (en) begin
            r_t_valid <= accept && (i_action == scv_pkg::ACTION_TERM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_coef         <= i_coefficient;
            r_t_ctl.row_end  <= i_row_end;
            r_t_ctl.last_row <= i_last_row;
            r_t_ctl.bound    <= i_bound;
        end
    end

    scv_store #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_store (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_req     (accept),
        .i_action  (i_action),
        .i_column  (i_column),
        .i_x_value (i_x_value),
        .o_rd_data (x_elem),
        .o_hit     (hit)
    );

    scv_mac u_mac (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_term_valid     (r_t_valid),
        .i_coefficient    (r_t_coef),
        .i_x_elem         (x_elem),
        .i_hit            (hit),
        .i_ctl            (r_t_ctl),
        .i_num_equalities (r_num_eq),
        .o_done           (row_done)
    );

    scv_metrics u_metrics (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_done          (row_done),
        .i_out_ready     (i_out_ready),
        .o_stall         (stall),
        .o_out_valid     (o_out_valid),
        .o_residual      (o_residual),
        .o_violation_sum (o_violation_sum),
        .o_violation_max (o_violation_max),
        .o_final_res     (o_final_res)
    );

endmodule
